/* hdl/smpq_pkg.sv */
package smpq_pkg;

    localparam int unsigned OP_W     = 2;
    localparam int unsigned VAL_W    = 32;
    localparam int unsigned STAT_W   = 2;
    localparam int unsigned OCC_W    = 4;
    localparam int unsigned S_DATA_W = 40;
    localparam int unsigned M_DATA_W = 40;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_PEEK   = 2'd1;
    localparam logic [OP_W-1:0] OP_POP    = 2'd2;

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic                load;
        logic                ins;
        logic                pop;
    } cmd_t;

    typedef struct packed {
        logic                full;
        logic                empty;
    } sts_t;

endpackage

/* hdl/smpq_ctrl.sv */
module smpq_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [smpq_pkg::OP_W-1:0]     op,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  smpq_pkg::sts_t                sts,
    output smpq_pkg::cmd_t                cmd
);
    import smpq_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_HOLD = 1'b1;

    logic state_reg;
    logic state_next;
    logic accept;

    assign s_tready = (state_reg == S_IDLE) || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = (state_reg == S_HOLD);

    always_comb begin
        cmd.load = accept;
        cmd.ins  = accept && (op == OP_INSERT) && !sts.full;
        cmd.pop  = accept && (op == OP_POP) && !sts.empty;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) state_next = S_HOLD;
            end
            S_HOLD: begin
                if (accept) state_next = S_HOLD;
                else if (m_tready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* hdl/smpq_datapath.sv */
module smpq_datapath #(
    parameter int unsigned CAPACITY = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  smpq_pkg::cmd_t                  cmd,
    input  logic [smpq_pkg::OP_W-1:0]       op,
    input  logic signed [smpq_pkg::VAL_W-1:0] value,
    output smpq_pkg::sts_t                  sts,
    output logic [smpq_pkg::M_DATA_W-1:0]   result
);
    import smpq_pkg::*;

    localparam int unsigned CW = $clog2(CAPACITY + 1);

    logic signed [VAL_W-1:0] store_reg  [CAPACITY];
    logic signed [VAL_W-1:0] store_next [CAPACITY];
    logic [CAPACITY-1:0]     gt;
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           count_next;
    logic [M_DATA_W-1:0]     result_reg;
    logic [STAT_W-1:0]       status;
    logic [VAL_W-1:0]        head;

    assign sts.full  = (count_reg >= CW'(CAPACITY));
    assign sts.empty = (count_reg == '0);

    // one compare-and-shift cell per entry
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        assign gt[i] = (CW'(i) < count_reg) && (value > store_reg[i]);

        always_comb begin
            store_next[i] = store_reg[i];
            if (cmd.ins) begin
                if (!gt[i]) begin
                    if (i == 0) begin
                        store_next[i] = value;
                    end else if (gt[(i > 0) ? i - 1 : 0]) begin
                        store_next[i] = value;
                    end else begin
                        store_next[i] = store_reg[(i > 0) ? i - 1 : 0];
                    end
                end
            end else if (cmd.pop) begin
                store_next[i] = store_reg[(i + 1 < CAPACITY) ? i + 1 : i];
            end
        end

        always_ff @(posedge aclk) begin
            store_reg[i] <= store_next[i];
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.ins) count_next = count_reg + CW'(1);
        else if (cmd.pop) count_next = count_reg - CW'(1);
    end

    always_comb begin
        status = ST_DONE;
        head   = '0;
        case (op) inside
            OP_INSERT: begin
                if (sts.full) status = ST_FULL;
            end
            OP_PEEK, OP_POP: begin
                if (sts.empty) begin
                    status = ST_EMPTY;
                end else begin
                    head = store_reg[0];
                end
            end
            default: begin
                status = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            result_reg <= {(count_next == '0),
                           (count_next >= CW'(CAPACITY)),
                           OCC_W'(count_next),
                           head,
                           status};
        end
    end

    assign result = result_reg;

endmodule

/* hdl/sorted_min_priority_queue_core.sv */
// Bounded minimum-first queue of CAPACITY signed 32-bit values kept sorted in a row of
// compare-and-shift cells. Each input word carries an operation (insert, peek, pop) and a
// value; each accepted word gives exactly one result word with status, head value,
// occupancy and full/empty flags. The whole operation completes in the accepting cycle,
// so one word is taken per clock; the result sits in an output register that frees itself
// in the same cycle it is taken, so back-pressure on the result side is the only stall.
// Equal values leave in insertion order reversed (a new value goes ahead of equal ones).
// Occupancy reports the low 4 bits of the stored count.
module sorted_min_priority_queue_core #(
    parameter int unsigned CAPACITY = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // operation[1:0], value[33:2], zero fill
    input  logic [smpq_pkg::S_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status[1:0], head_value[33:2], occupancy[37:34], is_full[38], is_empty[39]
    output logic [smpq_pkg::M_DATA_W-1:0] m_tdata
);
    import smpq_pkg::*;

    cmd_t                    cmd;
    sts_t                    sts;
    logic [OP_W-1:0]         op;
    logic signed [VAL_W-1:0] value;

    assign op    = s_tdata[OP_W-1:0];
    assign value = s_tdata[OP_W+VAL_W-1:OP_W];

    smpq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .op       (op),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    smpq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .op      (op),
        .value   (value),
        .sts     (sts),
        .result  (m_tdata)
    );

endmodule

/* hdl/smpq_checker.sv */
module smpq_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [smpq_pkg::M_DATA_W-1:0] m_tdata
);
    import smpq_pkg::*;

    // result word holds while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // every accepted word yields a result next cycle
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted word gave no result");

    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[38] && m_tdata[39]))
        else $error("full and empty together");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] == ST_EMPTY) |-> m_tdata[39] && (m_tdata[33:2] == '0))
        else $error("empty status inconsistent");

    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] == ST_FULL) |-> m_tdata[38] && (m_tdata[33:2] == '0))
        else $error("full status inconsistent");

endmodule

bind sorted_min_priority_queue_core smpq_checker u_smpq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
